/* sv/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, codes and helper functions of the playfair stream engine
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

    // default depth of the command queue between front and back
    localparam int PFC_QUEUE_DEPTH = 2;

    // letter codes, A is 0
    localparam logic [4:0] LTR_I       = 5'd8;
    localparam logic [4:0] LTR_J       = 5'd9;
    localparam logic [4:0] LTR_X       = 5'd23;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [4:0] SQUARE_CELLS = 5'd25;

    localparam logic [7:0] ASCII_UA   = 8'h41;
    localparam logic [7:0] ASCII_UZ   = 8'h5A;
    localparam logic [7:0] ASCII_LA   = 8'h61;
    localparam logic [7:0] ASCII_LZ   = 8'h7A;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    typedef enum logic [2:0] {
        REQ_KEY_START  = 3'd0,
        REQ_KEY_BYTE   = 3'd1,
        REQ_KEY_FINISH = 3'd2,
        REQ_TEXT_BYTE  = 3'd3,
        REQ_END_TEXT   = 3'd4
    } req_type_t;

    typedef enum logic [2:0] {
        CMD_KEY_START,
        CMD_KEY_LETTER,
        CMD_KEY_FINISH,
        CMD_TEXT,
        CMD_END
    } cmd_op_t;

    // command from the front to the back
    typedef struct packed {
        cmd_op_t    op;
        logic [4:0] letter;
        logic       ins_x;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_LOOKUP,
        BK_EMIT_A,
        BK_EMIT_B,
        BK_STATUS
    } back_state_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } cell_rc_t;

    // cell 0..24 split into row and column
    function automatic cell_rc_t pfc_split(input logic [4:0] pos);
        cell_rc_t   rc;
        logic [4:0] base;
        if (pos >= 5'd20) begin
            rc.row = 3'd4;
        end else if (pos >= 5'd15) begin
            rc.row = 3'd3;
        end else if (pos >= 5'd10) begin
            rc.row = 3'd2;
        end else if (pos >= 5'd5) begin
            rc.row = 3'd1;
        end else begin
            rc.row = 3'd0;
        end
        base   = {rc.row, 2'b00} + {2'b00, rc.row};
        rc.col = 3'(pos - base);
        return rc;
    endfunction

    function automatic logic [4:0] pfc_join(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // +1 mod 5 to encrypt, +4 mod 5 to decrypt
    function automatic logic [2:0] pfc_step(input logic [2:0] v, input logic dec);
        logic [2:0] r;
        if (dec) begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end else begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/playfair_cipher_stream.sv */
// ----------------------------------------------------------------------------
// playfair_cipher_stream
// playfair cipher over a byte stream with a 5x5 key square built from key bytes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    tuser req_type, tdata in_byte
//  m_        out        m_tvalid/m_tready    tdata out_char, tuser status, tlast
//  cfg_      in         cfg_valid/cfg_ready  cfg_data decrypt_mode
//
//  the front takes one request per cycle while the command queue has room
//  the back handles a key start, key letter, lone text letter or end of
//  text with nothing open in the idle state; a key finish is taken in idle,
//  then the fill state walks the alphabet; a letter pair goes through place
//  lookup, square lookup and then each output letter in turn through the
//  output register; a dropped odd tail goes through the status state
//  reset clears the build state; the square itself reads as the alphabet
//  until key letters overwrite it, through per-entry valid bits
//  a stalled m_ side holds the back, the queue then fills and drops s_tready
//
`default_nettype none

module playfair_cipher_stream #(
    parameter int QUEUE_DEPTH = pfc_pkg::PFC_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic [0:0]       m_tuser,   // [0] status, odd tail dropped
    output logic             m_tlast,   // last result of a request
    // mode register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data   // [0] decrypt_mode
);
    import pfc_pkg::*;

    logic decrypt_mode_reg, decrypt_mode_next;
    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_in, q_head;

    // mode register, always ready
    assign cfg_ready = 1'b1;

    always_comb begin
        decrypt_mode_next = decrypt_mode_reg;
        if (cfg_valid && cfg_ready) begin
            decrypt_mode_next = cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_mode_reg <= 1'b0;
        end else begin
            decrypt_mode_reg <= decrypt_mode_next;
        end
    end

    // front: normalize letters, track previous letter for x insertion
    pfc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .decrypt_mode (decrypt_mode_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    // command queue lets front and back stall on their own
    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // back: square build, pair mapping, output register
    pfc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .decrypt_mode (decrypt_mode_reg),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/pfc_front.sv */
// ----------------------------------------------------------------------------
// pfc_front
// takes input requests, normalizes letters, decides x insertion, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [2:0]    s_tuser,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          decrypt_mode,
    input  wire logic          q_full,
    output logic               q_push,
    output pfc_pkg::cmd_t      q_data
);
    import pfc_pkg::*;

    logic       accept;
    logic [7:0] up;
    logic [4:0] ofs;
    logic       is_ltr;
    logic [4:0] ltr;
    logic       prev_valid_reg, prev_valid_next;
    logic [4:0] prev_letter_reg, prev_letter_next;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        up = s_tdata;
        if (s_tdata >= ASCII_LA && s_tdata <= ASCII_LZ) begin
            up = s_tdata - CASE_GAP;
        end
        is_ltr = (up >= ASCII_UA) && (up <= ASCII_UZ);
        ofs    = 5'(up - ASCII_UA);
        ltr    = (ofs == LTR_J) ? LTR_I : ofs;
    end

    always_comb begin
        q_push           = 1'b0;
        q_data.op        = CMD_END;
        q_data.letter    = ltr;
        q_data.ins_x     = !decrypt_mode && prev_valid_reg && (prev_letter_reg == ltr);
        prev_valid_next  = prev_valid_reg;
        prev_letter_next = prev_letter_reg;
        case (s_tuser)
            REQ_KEY_START: begin
                q_data.op = CMD_KEY_START;
                q_push    = accept;
                if (accept) begin
                    prev_valid_next = 1'b0;
                end
            end
            REQ_KEY_BYTE: begin
                q_data.op = CMD_KEY_LETTER;
                q_push    = accept && is_ltr;
            end
            REQ_KEY_FINISH: begin
                q_data.op = CMD_KEY_FINISH;
                q_push    = accept;
            end
            REQ_TEXT_BYTE: begin
                q_data.op = CMD_TEXT;
                q_push    = accept && is_ltr;
                if (accept && is_ltr) begin
                    prev_valid_next  = 1'b1;
                    prev_letter_next = ltr;
                end
            end
            REQ_END_TEXT: begin
                q_data.op = CMD_END;
                q_push    = accept;
                if (accept) begin
                    prev_valid_next = 1'b0;
                end
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
        end else begin
            prev_valid_reg <= prev_valid_next;
        end
        prev_letter_reg <= prev_letter_next;
    end

endmodule

`default_nettype wire

/* sv/pfc_queue.sv */
// ----------------------------------------------------------------------------
// pfc_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_queue #(
    parameter int DEPTH = pfc_pkg::PFC_QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  pfc_pkg::cmd_t      push_data,
    output logic               full,
    input  wire logic          pop,
    output pfc_pkg::cmd_t      head,
    output logic               empty
);
    import pfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               slot [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/pfc_back.sv */
// ----------------------------------------------------------------------------
// pfc_back
// key square build, pair lookup and result output register
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          decrypt_mode,
    input  pfc_pkg::cmd_t      q_head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic [0:0]         m_tuser,
    output logic               m_tlast
);
    import pfc_pkg::*;

    // reset contents of the square and the place table
    function automatic logic [4:0] ks_reset(input logic [4:0] pos);
        return (pos <= LTR_I) ? pos : pos + 5'd1;
    endfunction

    function automatic logic [4:0] lp_reset(input logic [4:0] l);
        return (l <= LTR_I) ? l : l - 5'd1;
    endfunction

    back_state_t state_reg, state_next;

    logic [4:0]  ks_mem [25];
    logic [4:0]  lp_mem [26];
    logic [24:0] ks_vld_reg, ks_vld_next;
    logic [25:0] lp_vld_reg, lp_vld_next;

    logic [25:0] used_reg, used_next;
    logic [4:0]  fill_reg, fill_next;
    logic [4:0]  fill_idx_reg, fill_idx_next;
    logic        half_valid_reg, half_valid_next;
    logic [4:0]  half_reg, half_next;

    logic        place_req, place_ok;
    logic [4:0]  place_ltr;

    logic        lp_rd_en, ks_rd_en;
    logic [4:0]  lp_addr_a, lp_addr_b;
    logic [4:0]  lp_rd_a_reg, lp_rd_b_reg;
    logic [4:0]  ks_addr_a, ks_addr_b;
    logic [4:0]  ks_rd_a_reg, ks_rd_b_reg;
    cell_rc_t    rc_a, rc_b;

    logic        can_load;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign can_load = !out_valid_reg || m_tready;

    assign place_ok = place_req && (fill_reg < SQUARE_CELLS) && !used_reg[place_ltr];

    // pair geometry from the registered place reads
    always_comb begin
        rc_a = pfc_split(lp_rd_a_reg);
        rc_b = pfc_split(lp_rd_b_reg);
        if (rc_a.row == rc_b.row) begin
            ks_addr_a = pfc_join(rc_a.row, pfc_step(rc_a.col, decrypt_mode));
            ks_addr_b = pfc_join(rc_b.row, pfc_step(rc_b.col, decrypt_mode));
        end else if (rc_a.col == rc_b.col) begin
            ks_addr_a = pfc_join(pfc_step(rc_a.row, decrypt_mode), rc_a.col);
            ks_addr_b = pfc_join(pfc_step(rc_b.row, decrypt_mode), rc_b.col);
        end else begin
            ks_addr_a = pfc_join(rc_a.row, rc_b.col);
            ks_addr_b = pfc_join(rc_b.row, rc_a.col);
        end
    end

    always_comb begin
        state_next      = state_reg;
        q_pop           = 1'b0;
        used_next       = used_reg;
        fill_next       = fill_reg;
        fill_idx_next   = fill_idx_reg;
        half_valid_next = half_valid_reg;
        half_next       = half_reg;
        place_req       = 1'b0;
        place_ltr       = q_head.letter;
        lp_rd_en        = 1'b0;
        ks_rd_en        = 1'b0;
        lp_addr_a       = half_reg;
        lp_addr_b       = q_head.letter;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        CMD_KEY_START: begin
                            used_next       = '0;
                            fill_next       = '0;
                            half_valid_next = 1'b0;
                        end
                        CMD_KEY_LETTER: begin
                            place_req = 1'b1;
                        end
                        CMD_KEY_FINISH: begin
                            fill_idx_next = '0;
                            state_next    = BK_FILL;
                        end
                        CMD_TEXT: begin
                            if (q_head.ins_x) begin
                                // x goes in ahead of the repeated letter
                                if (half_valid_reg) begin
                                    lp_addr_a = half_reg;
                                    lp_addr_b = LTR_X;
                                end else begin
                                    lp_addr_a = LTR_X;
                                    lp_addr_b = q_head.letter;
                                end
                                lp_rd_en        = 1'b1;
                                state_next      = BK_LOOKUP;
                                half_valid_next = half_valid_reg;
                                half_next       = q_head.letter;
                            end else if (half_valid_reg) begin
                                lp_rd_en        = 1'b1;
                                state_next      = BK_LOOKUP;
                                half_valid_next = 1'b0;
                            end else begin
                                half_valid_next = 1'b1;
                                half_next       = q_head.letter;
                            end
                        end
                        CMD_END: begin
                            half_valid_next = 1'b0;
                            if (half_valid_reg) begin
                                if (decrypt_mode) begin
                                    state_next = BK_STATUS;
                                end else begin
                                    lp_addr_b  = LTR_X;
                                    lp_rd_en   = 1'b1;
                                    state_next = BK_LOOKUP;
                                end
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FILL: begin
                place_req     = (fill_idx_reg != LTR_J);
                place_ltr     = fill_idx_reg;
                fill_idx_next = fill_idx_reg + 5'd1;
                if (fill_idx_reg == LAST_LETTER) begin
                    state_next = BK_IDLE;
                end
            end
            BK_LOOKUP: begin
                ks_rd_en   = 1'b1;
                state_next = BK_EMIT_A;
            end
            BK_EMIT_A: begin
                if (can_load) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = ASCII_UA + {3'b000, ks_rd_a_reg};
                    out_status_next = 1'b0;
                    out_last_next   = 1'b0;
                    state_next      = BK_EMIT_B;
                end
            end
            BK_EMIT_B: begin
                if (can_load) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = ASCII_UA + {3'b000, ks_rd_b_reg};
                    out_status_next = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = BK_IDLE;
                end
            end
            BK_STATUS: begin
                if (can_load) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = '0;
                    out_status_next = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        ks_vld_next = ks_vld_reg;
        lp_vld_next = lp_vld_reg;
        if (place_ok) begin
            used_next              = used_reg | (26'd1 << place_ltr);
            fill_next              = fill_reg + 5'd1;
            ks_vld_next[fill_reg]  = 1'b1;
            lp_vld_next[place_ltr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            fill_reg       <= '0;
            fill_idx_reg   <= '0;
            half_valid_reg <= 1'b0;
            ks_vld_reg     <= '0;
            lp_vld_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            fill_idx_reg   <= fill_idx_next;
            half_valid_reg <= half_valid_next;
            ks_vld_reg     <= ks_vld_next;
            lp_vld_reg     <= lp_vld_next;
            out_valid_reg  <= out_valid_next;
        end
        half_reg       <= half_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // square and place memories, one write and two registered reads each
    always_ff @(posedge aclk) begin
        if (place_ok) begin
            ks_mem[fill_reg]  <= place_ltr;
            lp_mem[place_ltr] <= fill_reg;
        end
        if (lp_rd_en) begin
            lp_rd_a_reg <= lp_vld_reg[lp_addr_a] ? lp_mem[lp_addr_a] : lp_reset(lp_addr_a);
            lp_rd_b_reg <= lp_vld_reg[lp_addr_b] ? lp_mem[lp_addr_b] : lp_reset(lp_addr_b);
        end
        if (ks_rd_en) begin
            ks_rd_a_reg <= ks_vld_reg[ks_addr_a] ? ks_mem[ks_addr_a] : ks_reset(ks_addr_a);
            ks_rd_b_reg <= ks_vld_reg[ks_addr_b] ? ks_mem[ks_addr_b] : ks_reset(ks_addr_b);
        end
    end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks playfair_cipher_stream against a cycle-free playfair predictor
// ----------------------------------------------------------------------------
//
// requests go in on the s_ stream and letters come back on the m_ stream.
// each accepted request is run through the predictor, which keeps its own
// copy of the key square and text state and queues the letters it should
// produce. the checker pops one expectation per accepted result and compares
// char, status and last. both streams idle and stall at random. the mode
// register is only written once the engine has drained.
//
`timescale 1ns / 1ps

module testbench;

    import pfc_pkg::*;

    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 80;    // covers a key finish walk plus queue
    localparam int RANDOM_ITEMS  = 1500;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       status;
        logic       last;
    } cipher_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;   // [2:0] req_type
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_char
    logic [0:0]  m_tuser;   // [0] status
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;  // [0] decrypt_mode

    playfair_cipher_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------------
    logic [4:0]     sq_cell  [25];
    logic [4:0]     sq_place [26];
    logic [25:0]    sq_used;
    int             sq_fill;
    logic [4:0]     prev_ltr;
    logic           prev_ok;
    logic [4:0]     half_ltr;
    logic           half_ok;
    logic           mode_dec;

    cipher_result_t expected_letters[$];
    int             mismatch_count;
    int             items_sent;
    int             send_calm;
    int             recv_calm;

    // letter code with J folded to I, -1 for anything that is not a letter
    function automatic int fold_letter(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (v >= ASCII_LA && v <= ASCII_LZ) v = v - CASE_GAP;
        if (v < ASCII_UA || v > ASCII_UZ) return -1;
        v = v - ASCII_UA;
        if (v[4:0] == LTR_J) v = {3'b000, LTR_I};
        return int'(v);
    endfunction

    task automatic square_reset();
        int k;
        k = 0;
        for (int i = 0; i < 26; i++) begin
            if (i != int'(LTR_J)) begin
                sq_cell[k]  = 5'(i);
                sq_place[i] = 5'(k);
                k++;
            end
        end
        sq_place[LTR_J] = sq_place[LTR_I];
        sq_used  = '0;
        sq_fill  = 0;
        prev_ltr = '0;
        prev_ok  = 1'b0;
        half_ltr = '0;
        half_ok  = 1'b0;
        mode_dec = 1'b0;
    endtask

    task automatic square_place(input logic [4:0] l);
        if (sq_fill >= 25 || sq_used[l]) return;
        sq_cell[sq_fill] = l;
        sq_place[l]      = 5'(sq_fill);
        if (l == LTR_I) sq_place[LTR_J] = 5'(sq_fill);
        sq_used[l] = 1'b1;
        sq_fill++;
    endtask

    task automatic queue_result(input logic [7:0] ch, input logic st);
        cipher_result_t r;
        r.ch     = ch;
        r.status = st;
        r.last   = 1'b0;
        expected_letters = {expected_letters, r};
    endtask

    // same row shifts along the row, same column along the column,
    // otherwise the corners of the rectangle swap columns
    task automatic cipher_pair(input logic [4:0] a, input logic [4:0] b);
        int pa, pb, r1, c1, r2, c2, sh, o1, o2;
        pa = int'(sq_place[a]) % 25;
        pb = int'(sq_place[b]) % 25;
        r1 = pa / 5;
        c1 = pa % 5;
        r2 = pb / 5;
        c2 = pb % 5;
        sh = mode_dec ? 4 : 1;
        if (r1 == r2) begin
            o1 = r1 * 5 + (c1 + sh) % 5;
            o2 = r2 * 5 + (c2 + sh) % 5;
        end else if (c1 == c2) begin
            o1 = ((r1 + sh) % 5) * 5 + c1;
            o2 = ((r2 + sh) % 5) * 5 + c2;
        end else begin
            o1 = r1 * 5 + c2;
            o2 = r2 * 5 + c1;
        end
        queue_result(ASCII_UA + 8'(sq_cell[o1]), 1'b0);
        queue_result(ASCII_UA + 8'(sq_cell[o2]), 1'b0);
    endtask

    task automatic feed_letter(input logic [4:0] l);
        if (!half_ok) begin
            half_ltr = l;
            half_ok  = 1'b1;
        end else begin
            half_ok = 1'b0;
            cipher_pair(half_ltr, l);
        end
    endtask

    task automatic predict_request(input logic [2:0] req, input logic [7:0] data);
        int             n0;
        int             l;
        n0 = expected_letters.size();
        case (req)
            REQ_KEY_START: begin
                sq_used = '0;
                sq_fill = 0;
                prev_ok = 1'b0;
                half_ok = 1'b0;
            end
            REQ_KEY_BYTE: begin
                l = fold_letter(data);
                if (l >= 0) square_place(5'(l));
            end
            REQ_KEY_FINISH: begin
                for (int i = 0; i < 26; i++)
                    if (i != int'(LTR_J)) square_place(5'(i));
            end
            REQ_TEXT_BYTE: begin
                l = fold_letter(data);
                if (l >= 0) begin
                    // doubled letters get an X between them when encrypting
                    if (!mode_dec && prev_ok && prev_ltr == 5'(l)) feed_letter(LTR_X);
                    feed_letter(5'(l));
                    prev_ltr = 5'(l);
                    prev_ok  = 1'b1;
                end
            end
            REQ_END_TEXT: begin
                if (half_ok) begin
                    if (mode_dec) begin
                        half_ok = 1'b0;
                        queue_result(8'h00, 1'b1);
                    end else begin
                        feed_letter(LTR_X);
                    end
                end
                prev_ok = 1'b0;
                half_ok = 1'b0;
            end
            default: ;
        endcase
        if (expected_letters.size() > n0)
            expected_letters[expected_letters.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // idling: mostly none or short, a few long, now and then a calm stretch
    // ------------------------------------------------------------------------
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_letter_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return ASCII_UA + 8'($urandom_range(0, 25));
        if (r < 88) return ASCII_LA + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers, always entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] req, input logic [7:0] data);
        int gap;
        gap = pick_gap(send_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        predict_request(req, data);
        if (req <= REQ_END_TEXT) items_sent++;
        @(negedge aclk);
    endtask

    // mode writes wait for the engine to drain, including requests that
    // leave no result behind
    task automatic write_mode(input logic dec);
        s_tvalid <= 1'b0;
        while (expected_letters.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= dec;
        do @(posedge aclk); while (!cfg_ready);
        mode_dec = dec;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_request(REQ_TEXT_BYTE, s[i]);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // square as it comes out of reset, J folding, dropped bytes, doubled
    // letters across pairs and tail padding
    task automatic test_default_square();
        send_text("aJ");
        send_request(REQ_TEXT_BYTE, 8'h00);
        send_request(REQ_TEXT_BYTE, 8'hFF);
        send_text("Iz");
        send_request(REQ_END_TEXT, 8'h00);
    endtask

    task automatic test_unused_codes();
        for (int c = int'(REQ_END_TEXT) + 1; c < 8; c++)
            send_request(3'(c), "A");
    endtask

    // key letter on top of the reset build state, then text on the mixed square
    task automatic test_key_without_start();
        send_request(REQ_KEY_BYTE, "z");
        send_text("AZ");
    endtask

    // key with case folding, non-letters, J and I colliding, double finish
    // and a key letter once the square is full
    task automatic test_key_build();
        send_request(REQ_KEY_START, 8'hFF);
        send_request(REQ_KEY_BYTE, "K");
        send_request(REQ_KEY_BYTE, "e");
        send_request(REQ_KEY_BYTE, "5");
        send_request(REQ_KEY_BYTE, "j");
        send_request(REQ_KEY_BYTE, "i");
        send_request(REQ_KEY_FINISH, 8'h00);
        send_request(REQ_KEY_FINISH, 8'h00);
        send_request(REQ_KEY_BYTE, "Q");
    endtask

    // decrypt with a dropped odd tail, then switch to encrypt with a half
    // pair open so the pair completes under the new mode
    task automatic test_mode_switch();
        write_mode(1'b1);
        send_text("hel");
        send_request(REQ_END_TEXT, 8'h00);
        send_text("A");
        write_mode(1'b0);
        send_text("A");
        send_request(REQ_END_TEXT, 8'h00);
    endtask

    task automatic test_random_streams();
        int         start;
        int         shape;
        int         cnt;
        logic [7:0] last_byte;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            write_mode(1'($urandom_range(0, 1)));
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
                // well-formed key
                send_request(REQ_KEY_START, 8'($urandom_range(0, 255)));
                cnt = $urandom_range(0, 30);
                repeat (cnt) send_request(REQ_KEY_BYTE, rand_letter_byte());
                send_request(REQ_KEY_FINISH, 8'($urandom_range(0, 255)));
            end else if (shape == 7) begin
                // unfinished key, text sees a mixed square
                cnt = $urandom_range(1, 12);
                repeat (cnt) send_request(REQ_KEY_BYTE, rand_letter_byte());
            end else begin
                cnt = $urandom_range(5, 20);
                repeat (cnt)
                    send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            cnt = $urandom_range(0, 40);
            last_byte = rand_letter_byte();
            repeat (cnt) begin
                if ($urandom_range(0, 99) >= 15) last_byte = rand_letter_byte();
                send_request(REQ_TEXT_BYTE, last_byte);
            end
            // sometimes leave the text open so the next mode applies mid text
            if ($urandom_range(0, 4) != 0)
                send_request(REQ_END_TEXT, 8'($urandom_range(0, 255)));
        end
        send_request(REQ_END_TEXT, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // result stream: random stalls and the checker
    // ------------------------------------------------------------------------
    initial begin : result_pacing
        int stall;
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            stall = pick_gap(recv_calm);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cipher_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_letters.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result expected none got char %h status %b last %b",
                             $time, m_tdata, m_tuser[0], m_tlast);
            end else begin
                want = expected_letters.pop_front();
                if (m_tdata !== want.ch || m_tuser[0] !== want.status ||
                    m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected char %h status %b last %b got %h %b %b",
                                 $time, want.ch, want.status, want.last,
                                 m_tdata, m_tuser[0], m_tlast);
                end
            end
        end
    end

    // ends the run when no handshake happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = '0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        items_sent     = 0;
        send_calm      = 0;
        recv_calm      = 0;
        square_reset();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_square();
        test_unused_codes();
        test_key_without_start();
        test_key_build();
        test_mode_switch();
        test_random_streams();

        s_tvalid <= 1'b0;
        while (expected_letters.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_letters.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
